/* rtl/core/stereo_wavetable_voice_mixer_unit_defines.svh */
// assertion macros for the stereo wavetable voice mixer
`ifndef STEREO_WAVETABLE_VOICE_MIXER_UNIT_DEFINES_SVH
`define STEREO_WAVETABLE_VOICE_MIXER_UNIT_DEFINES_SVH

// antecedent in this cycle implies consequent in the next cycle
`define SWVM_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("swvm next-cycle check failed");

// antecedent implies consequent in the same cycle
`define SWVM_ASSERT_SAME(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("swvm same-cycle check failed");

`endif

/* rtl/core/swvm_pkg.sv */
// shared types, codes and constants of the stereo wavetable voice mixer
`timescale 1ns / 1ps
package swvm_pkg;

  localparam int TABLE_DEPTH_DEF = 65536;
  localparam int ADDR_EXT_W      = 21;
  localparam int LEN_W           = 17;
  localparam int CFG_IDX_W       = 2;
  localparam int STEP_W          = 3;

  localparam logic [1:0] FUNC_LOAD_LOOP = 2'd0;
  localparam logic [1:0] FUNC_LOAD_SHOT = 2'd1;
  localparam logic [1:0] FUNC_FRAME     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHOT_LENGTH = 2'd1;

  localparam logic [LEN_W-1:0] LEN_MAX        = 17'h10000;
  localparam logic [LEN_W-1:0] LOOP_LEN_RESET = 17'h10000;
  localparam logic [LEN_W-1:0] SHOT_LEN_RESET = 17'h00000;
  localparam logic [15:0]      WEIGHT_ONE     = 16'h8000;

  // multiplier schedule, one product per cycle
  localparam logic [STEP_W-1:0] STEP_LOOP_AMP   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SHOT_AMP   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LOOP_LEFT  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LOOP_RIGHT = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SHOT_LEFT  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_SHOT_RIGHT = 3'd5;
  localparam logic [STEP_W-1:0] STEP_ACC_RIGHT  = 3'd6;

  typedef struct packed {
    logic               en;
    logic               sel_shot;
    logic [15:0]        addr;
    logic signed [15:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic        en;
    logic [15:0] loop_addr;
    logic [15:0] shot_addr;
    logic        shot_need;
  } tbl_rd_t;

  typedef struct packed {
    logic              en;
    logic [STEP_W-1:0] step;
  } mix_ctl_t;

  typedef struct packed {
    logic [15:0] amp;
    logic [15:0] bal;
    logic [15:0] rbal;
    logic [18:0] samp5;
    logic [15:0] sbal;
    logic [15:0] srbal;
  } mix_coef_t;

endpackage

/* rtl/core/swvm_ifs.sv */
// channel interfaces: input items, results and register writes
`timescale 1ns / 1ps
interface swvm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [15:0]        load_addr;
  logic signed [15:0] load_sample;
  logic [15:0]        loop_amp;
  logic [15:0]        loop_bal;
  logic [15:0]        shot_amp;
  logic [15:0]        shot_bal;
  logic               shot_trigger;

  modport source (output valid, func, load_addr, load_sample, loop_amp, loop_bal,
                  shot_amp, shot_bal, shot_trigger, input ready);
  modport sink (input valid, func, load_addr, load_sample, loop_amp, loop_bal,
                shot_amp, shot_bal, shot_trigger, output ready);
endinterface

interface swvm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic               shot_active;

  modport source (output valid, left_out, right_out, shot_active, input ready);
  modport sink (input valid, left_out, right_out, shot_active, output ready);
endinterface

interface swvm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/swvm_table_mem.sv */
// loop and one-shot sample tables, one write and one registered read each
`timescale 1ns / 1ps
module swvm_table_mem
  import swvm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  tbl_wr_t            wr,
  input  tbl_rd_t            rd,
  output logic signed [15:0] loop_sample,
  output logic signed [15:0] shot_sample
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [ADDR_EXT_W-1:0] DEPTH_V = ADDR_EXT_W'(TABLE_DEPTH);

  logic signed [15:0] loop_mem [TABLE_DEPTH];
  logic signed [15:0] shot_mem [TABLE_DEPTH];

  logic [ADDR_EXT_W-1:0] wr_ext, loop_ext, shot_ext;
  logic                  wr_ok, loop_ok, shot_ok;
  logic signed [15:0]    loop_q_r, shot_q_r;
  logic                  loop_ok_r, shot_ok_r;

  assign wr_ext   = ADDR_EXT_W'(wr.addr);
  assign loop_ext = ADDR_EXT_W'(rd.loop_addr);
  assign shot_ext = ADDR_EXT_W'(rd.shot_addr);
  assign wr_ok    = wr_ext < DEPTH_V;
  assign loop_ok  = loop_ext < DEPTH_V;
  assign shot_ok  = (shot_ext < DEPTH_V) && rd.shot_need;

  always_ff @(posedge clk) begin
    if (wr.en && wr_ok && !wr.sel_shot) begin
      loop_mem[wr_ext[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr_ok && wr.sel_shot) begin
      shot_mem[wr_ext[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      loop_q_r  <= loop_mem[loop_ext[AW-1:0]];
      shot_q_r  <= shot_mem[shot_ext[AW-1:0]];
      loop_ok_r <= loop_ok;
      shot_ok_r <= shot_ok;
    end
  end

  // out-of-range or idle voice reads as silence
  assign loop_sample = loop_ok_r ? loop_q_r : 16'sd0;
  assign shot_sample = shot_ok_r ? shot_q_r : 16'sd0;

endmodule

/* rtl/core/swvm_mix_dp.sv */
// shared multiplier, left/right accumulators, rounding and saturation
`timescale 1ns / 1ps
module swvm_mix_dp
  import swvm_pkg::*;
(
  input  logic               clk,
  input  mix_ctl_t           ctl,
  input  mix_coef_t          coef,
  input  logic signed [15:0] loop_sample,
  input  logic signed [15:0] shot_sample,
  output logic signed [15:0] left_out,
  output logic signed [15:0] right_out
);

  localparam int ACC_W = 52;
  localparam int QW    = ACC_W - 29;
  localparam logic signed [ACC_W-1:0] RND_HALF = {{(ACC_W-29){1'b0}}, 1'b1, 28'd0};
  localparam logic signed [QW-1:0]    Q_MAX    = QW'(32767);
  localparam logic signed [QW-1:0]    Q_MIN    = -QW'(32768);

  logic signed [32:0]      ls_r;
  logic signed [34:0]      ts_r;
  logic signed [ACC_W-1:0] prod_r, acc_l_r, acc_r_r;
  logic signed [35:0]      x;
  logic signed [19:0]      y;
  logic signed [55:0]      mult;
  logic signed [ACC_W-1:0] sum_l, sum_r;

  function automatic logic signed [15:0] sat_q(input logic signed [QW-1:0] q);
    logic signed [15:0] r;
    if (q > Q_MAX) begin
      r = 16'sh7fff;
    end else if (q < Q_MIN) begin
      r = -16'sh8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  always_comb begin
    x = '0;
    y = '0;
    case (ctl.step)
      STEP_LOOP_AMP: begin
        x = {{20{loop_sample[15]}}, loop_sample};
        y = {4'd0, coef.amp};
      end
      STEP_SHOT_AMP: begin
        x = {{20{shot_sample[15]}}, shot_sample};
        y = {1'b0, coef.samp5};
      end
      STEP_LOOP_LEFT: begin
        x = {{3{ls_r[32]}}, ls_r};
        y = {4'd0, coef.bal};
      end
      STEP_LOOP_RIGHT: begin
        x = {{3{ls_r[32]}}, ls_r};
        y = {4'd0, coef.rbal};
      end
      STEP_SHOT_LEFT: begin
        x = {ts_r[34], ts_r};
        y = {4'd0, coef.sbal};
      end
      STEP_SHOT_RIGHT: begin
        x = {ts_r[34], ts_r};
        y = {4'd0, coef.srbal};
      end
      default: begin
        x = '0;
        y = '0;
      end
    endcase
  end

  assign mult = x * y;

  // each product is registered in prod_r, and the step that follows consumes it
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= mult[ACC_W-1:0];
      case (ctl.step)
        STEP_SHOT_AMP:   ls_r    <= prod_r[32:0];
        STEP_LOOP_LEFT:  ts_r    <= prod_r[34:0];
        STEP_LOOP_RIGHT: acc_l_r <= prod_r;
        STEP_SHOT_LEFT:  acc_r_r <= prod_r;
        STEP_SHOT_RIGHT: acc_l_r <= acc_l_r + prod_r;
        STEP_ACC_RIGHT:  acc_r_r <= acc_r_r + prod_r;
        default: begin
        end
      endcase
    end
  end

  // round half up to q1.15, then clip
  assign sum_l = acc_l_r + RND_HALF;
  assign sum_r = acc_r_r + RND_HALF;
  assign left_out  = sat_q(signed'(sum_l[ACC_W-1:29]));
  assign right_out = sat_q(signed'(sum_r[ACC_W-1:29]));

endmodule

/* rtl/core/swvm_seq.sv */
// item sequencer: voice positions, loop wrap remainder, table and multiplier control
`timescale 1ns / 1ps
module swvm_seq
  import swvm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  swvm_in_if.sink          in_ch,
  input  logic [LEN_W-1:0] loop_len_eff,
  input  logic [LEN_W-1:0] shot_len_eff,
  input  logic             res_take,
  output tbl_wr_t          tbl_wr,
  output tbl_rd_t          tbl_rd,
  output mix_ctl_t         mix_ctl,
  output mix_coef_t        mix_coef,
  output logic             res_valid,
  output logic             shot_active
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [15:0]       loop_pos_r, loop_pos_nxt;
  logic [16:0]       shot_pos_r, shot_pos_nxt;
  logic              shot_play_r, shot_play_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              shot_need_r, shot_need_nxt;
  logic [15:0]       shot_addr_r, shot_addr_nxt;
  logic              active_r, active_nxt;
  mix_coef_t         coef_r, coef_nxt;

  logic        accept, frame_acc;
  logic        play1, need, play2;
  logic [16:0] pos1, pos2;
  logic [31:0] len_sh;
  logic [15:0] lbal, sbal;

  function automatic logic [15:0] clamp_bal(input logic [15:0] b);
    return (b > WEIGHT_ONE) ? WEIGHT_ONE : b;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign frame_acc   = accept && (in_ch.func == FUNC_FRAME);

  always_comb begin
    tbl_wr.en       = accept && ((in_ch.func == FUNC_LOAD_LOOP) ||
                                 (in_ch.func == FUNC_LOAD_SHOT));
    tbl_wr.sel_shot = (in_ch.func == FUNC_LOAD_SHOT);
    tbl_wr.addr     = in_ch.load_addr;
    tbl_wr.data     = in_ch.load_sample;
  end

  // one-shot voice step, resolved when the frame is taken
  always_comb begin
    play1 = in_ch.shot_trigger || shot_play_r;
    pos1  = in_ch.shot_trigger ? 17'd0 : shot_pos_r;
    need  = play1 && (pos1 < shot_len_eff);
    pos2  = need ? pos1 + 17'd1 : pos1;
    play2 = play1 && (pos2 < shot_len_eff);
  end

  assign lbal   = clamp_bal(in_ch.loop_bal);
  assign sbal   = clamp_bal(in_ch.shot_bal);
  assign len_sh = {15'd0, loop_len_eff} << cnt_r;

  always_comb begin
    state_nxt     = state_r;
    loop_pos_nxt  = loop_pos_r;
    shot_pos_nxt  = shot_pos_r;
    shot_play_nxt = shot_play_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    shot_need_nxt = shot_need_r;
    shot_addr_nxt = shot_addr_r;
    active_nxt    = active_r;
    coef_nxt      = coef_r;
    tbl_rd.en        = 1'b0;
    tbl_rd.loop_addr = rem_r;
    tbl_rd.shot_addr = shot_addr_r;
    tbl_rd.shot_need = shot_need_r;
    mix_ctl.en   = 1'b0;
    mix_ctl.step = step_r;
    res_valid    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (frame_acc) begin
          shot_pos_nxt   = pos2;
          shot_play_nxt  = play2;
          active_nxt     = play2;
          shot_need_nxt  = need;
          shot_addr_nxt  = pos1[15:0];
          rem_nxt        = loop_pos_r;
          cnt_nxt        = 4'd15;
          coef_nxt.amp   = in_ch.loop_amp;
          coef_nxt.bal   = lbal;
          coef_nxt.rbal  = WEIGHT_ONE - lbal;
          coef_nxt.samp5 = {1'b0, in_ch.shot_amp, 2'b00} + {3'b000, in_ch.shot_amp};
          coef_nxt.sbal  = sbal;
          coef_nxt.srbal = WEIGHT_ONE - sbal;
          state_nxt      = S_MOD;
        end
      end
      S_MOD: begin
        // restoring remainder, runs once the position reaches the loop length
        if ({16'd0, rem_r} < {15'd0, loop_len_eff}) begin
          state_nxt = S_RD;
        end else begin
          if ({16'd0, rem_r} >= len_sh) begin
            rem_nxt = rem_r - len_sh[15:0];
          end
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      S_RD: begin
        tbl_rd.en    = 1'b1;
        loop_pos_nxt = rem_r + 16'd1;
        step_nxt     = STEP_LOOP_AMP;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        mix_ctl.en = 1'b1;
        step_nxt   = step_r + 3'd1;
        if (step_r == STEP_ACC_RIGHT) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loop_pos_r  <= '0;
      shot_pos_r  <= '0;
      shot_play_r <= 1'b0;
      step_r      <= STEP_LOOP_AMP;
    end else begin
      state_r     <= state_nxt;
      loop_pos_r  <= loop_pos_nxt;
      shot_pos_r  <= shot_pos_nxt;
      shot_play_r <= shot_play_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    shot_need_r <= shot_need_nxt;
    shot_addr_r <= shot_addr_nxt;
    active_r    <= active_nxt;
    coef_r      <= coef_nxt;
  end

  assign mix_coef    = coef_r;
  assign shot_active = active_r;

endmodule

/* rtl/core/stereo_wavetable_voice_mixer_unit.sv */
// top level of the two-voice stereo wavetable mixer
//
//   channel  dir  transaction                         payload
//   in_ch    in   load sample or produce one frame    func, address, sample, gains, trigger
//   out_ch   out  one stereo frame                    left_out, right_out, shot_active
//   cfg_ch   in   register write, always ready        index, data
//
// a load is written as it is accepted, and in_ch stays ready; a frame keeps in_ch busy
// through the single shared multiplier (six products) and the registered table read
// once the play position reaches the loop length (each wrap of a shorter loop, or a
// lowered length), a frame first reduces the position by the restoring remainder
// the output register lets the next item in while a frame waits
// reset zeroes positions and voice state and restores the length defaults; the tables
// are undefined until written
`timescale 1ns / 1ps
module stereo_wavetable_voice_mixer_unit
  import swvm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  swvm_in_if.sink   in_ch,
  swvm_out_if.source out_ch,
  swvm_cfg_if.sink  cfg_ch
);

  logic [LEN_W-1:0]   loop_len_r, loop_len_nxt;
  logic [LEN_W-1:0]   shot_len_r, shot_len_nxt;
  logic [LEN_W-1:0]   loop_len_eff, shot_len_eff;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_left_r, out_right_r;
  logic               out_active_r;
  logic               cfg_acc, res_take, res_valid, shot_active;
  logic signed [15:0] mix_left, mix_right, loop_sample, shot_sample;
  tbl_wr_t            tbl_wr;
  tbl_rd_t            tbl_rd;
  mix_ctl_t           mix_ctl;
  mix_coef_t          mix_coef;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    loop_len_nxt = loop_len_r;
    shot_len_nxt = shot_len_r;
    if (cfg_acc) begin
      case (cfg_ch.index)
        REG_LOOP_LENGTH: loop_len_nxt = cfg_ch.data;
        REG_SHOT_LENGTH: shot_len_nxt = cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // loop length zero plays one sample; both lengths clip to LEN_MAX, the 16-bit address span
  always_comb begin
    if (loop_len_r == '0) begin
      loop_len_eff = 17'd1;
    end else if (loop_len_r > LEN_MAX) begin
      loop_len_eff = LEN_MAX;
    end else begin
      loop_len_eff = loop_len_r;
    end
    shot_len_eff = (shot_len_r > LEN_MAX) ? LEN_MAX : shot_len_r;
  end

  swvm_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .loop_len_eff (loop_len_eff),
    .shot_len_eff (shot_len_eff),
    .res_take     (res_take),
    .tbl_wr       (tbl_wr),
    .tbl_rd       (tbl_rd),
    .mix_ctl      (mix_ctl),
    .mix_coef     (mix_coef),
    .res_valid    (res_valid),
    .shot_active  (shot_active)
  );

  swvm_table_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table_mem (
    .clk         (clk),
    .wr          (tbl_wr),
    .rd          (tbl_rd),
    .loop_sample (loop_sample),
    .shot_sample (shot_sample)
  );

  swvm_mix_dp u_mix_dp (
    .clk         (clk),
    .ctl         (mix_ctl),
    .coef        (mix_coef),
    .loop_sample (loop_sample),
    .shot_sample (shot_sample),
    .left_out    (mix_left),
    .right_out   (mix_right)
  );

  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_len_r  <= LOOP_LEN_RESET;
      shot_len_r  <= SHOT_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      loop_len_r  <= loop_len_nxt;
      shot_len_r  <= shot_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_left_r   <= mix_left;
      out_right_r  <= mix_right;
      out_active_r <= shot_active;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_out    = out_left_r;
  assign out_ch.right_out   = out_right_r;
  assign out_ch.shot_active = out_active_r;

endmodule

/* rtl/core/swvm_checker.sv */
// port-level checker for the mixer top level, with its bind
`timescale 1ns / 1ps
`include "stereo_wavetable_voice_mixer_unit_defines.svh"
module swvm_checker
  import swvm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_left,
  input logic [15:0] out_right,
  input logic        out_active
);

  `SWVM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SWVM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({out_left, out_right, out_active}))
  // no item yields a result in the cycle right after it is taken
  `SWVM_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready && !out_valid, !out_valid)
  // a taken frame keeps the block busy, so in_ready drops after it
  `SWVM_ASSERT_NEXT(a_frame_busy, in_valid && in_ready && (in_func == FUNC_FRAME), !in_ready)

endmodule

bind stereo_wavetable_voice_mixer_unit swvm_checker u_swvm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_func    (in_ch.func),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_left   (out_ch.left_out),
  .out_right  (out_ch.right_out),
  .out_active (out_ch.shot_active)
);
